// ===== design/lthd_pkg.sv =====
// Shared types and constants of the light target hit detector.
// Phase codes, configuration register indexes, reset values and the result item.
// No dependencies.
package lthd_pkg;

    localparam int TGT_W  = 2;
    localparam int LED_W  = 3;
    localparam int BASE_W = 12;
    localparam int CONF_W = 4;
    localparam int WAIT_W = 16;
    localparam int TIME_W = 32;
    localparam int DRAW_W = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        PH_SELECT = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_WAIT   = 2'd2
    } phase_t;

    localparam logic [TGT_W-1:0] NO_TARGET = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_HIT_DELTA      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM_NEEDED = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_MS        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_A         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_B         = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_C         = 3'd5;

    localparam logic [BASE_W-1:0] DELTA_RST   = 12'd200;
    localparam logic [CONF_W-1:0] CONFIRM_RST = 4'd3;
    localparam logic [WAIT_W-1:0] WAIT_RST    = 16'd1000;
    localparam logic [BASE_W-1:0] BASE_RST    = 12'd4095;
    localparam logic [BASE_W-1:0] LEVEL_RST   = BASE_RST - DELTA_RST;

    typedef struct packed {
        logic [TGT_W-1:0] target;
        logic [LED_W-1:0] led_mask;
        logic             hit;
        logic [1:0]       phase_now;
    } result_t;

endpackage

// ===== design/light_target_hit_detector_top.sv =====
// Light target hit detector: phase machine, per-sensor baseline tracking and
// result buffering. Depends on lthd_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one update tick per item:
//   sample, laser_on, random_draw and now_ms. Output channel (out_valid /
//   out_stall) returns exactly one result item per tick: target, led_mask,
//   hit and phase_now after the tick.
//   The result of an item is registered at its accepting edge, into the
//   output register, or into the skid entry while the receiver stalls.
//   Throughput: one item per cycle while in_stall is low; the whole update
//   is a single pass of short logic between state and result registers.
//   The output has a main register and one skid entry; in_stall rises only
//   when the skid entry is full, so one more item is taken while a result
//   waits on a stalled receiver. Nothing is dropped or repeated.
//   Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
//   a baseline write also reloads that sensor's baseline and threshold.
//   Reset: phase select, no target, baselines 4095, thresholds 3895, output
//   empty, configuration back to its reset values.
module light_target_hit_detector_top #(
    parameter int SENSORS     = 3,
    parameter int SAMPLE_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [SAMPLE_BITS-1:0]           sample,
    input  logic                             laser_on,
    input  logic [lthd_pkg::DRAW_W-1:0]      random_draw,
    input  logic [lthd_pkg::TIME_W-1:0]      now_ms,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [lthd_pkg::TGT_W-1:0]       target,
    output logic [lthd_pkg::LED_W-1:0]       led_mask,
    output logic                             hit,
    output logic [1:0]                       phase_now,
    input  logic                             cfg_we,
    input  logic [lthd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [lthd_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int AW = (SAMPLE_BITS > lthd_pkg::BASE_W) ? SAMPLE_BITS : lthd_pkg::BASE_W;
    localparam int IW = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam logic [lthd_pkg::TGT_W-1:0] SENS_N = lthd_pkg::TGT_W'(SENSORS);

    function automatic logic [AW-1:0] floor_sub(input logic [AW-1:0] b,
                                                input logic [AW-1:0] d);
        floor_sub = (b > d) ? (b - d) : '0;
    endfunction

    logic [lthd_pkg::BASE_W-1:0] hit_delta_reg;
    logic [lthd_pkg::CONF_W-1:0] confirm_needed_reg;
    logic [lthd_pkg::WAIT_W-1:0] wait_ms_reg;

    lthd_pkg::phase_t             phase_reg, phase_next;
    logic [lthd_pkg::TGT_W-1:0]   cur_tgt_reg, cur_tgt_next;
    logic [lthd_pkg::TGT_W-1:0]   last_tgt_reg, last_tgt_next;
    logic [lthd_pkg::TIME_W-1:0]  wait_start_reg, wait_start_next;
    logic [lthd_pkg::CONF_W-1:0]  count_reg, count_next;
    logic [AW-1:0]                ambient_reg [SENSORS];
    logic [AW-1:0]                level_reg [SENSORS];

    logic                         out_valid_reg, skid_valid_reg;
    lthd_pkg::result_t            out_reg, skid_reg, res_next;

    logic                         in_acc;
    logic                         amb_we;
    logic [IW-1:0]                tidx;
    logic [AW-1:0]                amb_cur, lvl_cur, amb_upd, lvl_upd;
    logic [AW+5:0]                amb_sum;
    logic [lthd_pkg::TGT_W-1:0]   draw_t, pick_t;
    logic                         hit_now;
    logic [lthd_pkg::TIME_W-1:0]  elapsed;
    logic [lthd_pkg::CFG_IDX_W-1:0] base_sel;
    logic                         base_wr;
    logic [AW-1:0]                base_val;
    logic [AW-1:0]                base_lvl;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !skid_valid_reg;

    assign tidx    = cur_tgt_reg[IW-1:0];
    assign amb_cur = ambient_reg[tidx];
    assign lvl_cur = level_reg[tidx];
    assign amb_sum = (AW+6)'({amb_cur, 5'b0}) - (AW+6)'(amb_cur) + (AW+6)'(sample);
    assign amb_upd = AW'(amb_sum[SAMPLE_BITS+4:5]);
    assign lvl_upd = floor_sub(amb_upd, AW'(hit_delta_reg));
    assign elapsed = now_ms - wait_start_reg;

    always_comb
    begin
        draw_t = lthd_pkg::TGT_W'(random_draw);
        if (draw_t >= SENS_N)
        begin
            draw_t = draw_t - SENS_N;
        end
        pick_t = draw_t;
        if (draw_t == last_tgt_reg)
        begin
            pick_t = (draw_t + 1'b1 == SENS_N) ? '0 : draw_t + 1'b1;
        end
    end

    always_comb
    begin
        phase_next      = phase_reg;
        cur_tgt_next    = cur_tgt_reg;
        last_tgt_next   = last_tgt_reg;
        wait_start_next = wait_start_reg;
        count_next      = count_reg;
        amb_we          = 1'b0;
        hit_now         = 1'b0;
        unique case (phase_reg)
            lthd_pkg::PH_SELECT:
            begin
                cur_tgt_next = pick_t;
                count_next   = '0;
                phase_next   = lthd_pkg::PH_ACTIVE;
            end
            lthd_pkg::PH_ACTIVE:
            begin
                if (cur_tgt_reg < SENS_N)
                begin
                    if (!laser_on)
                    begin
                        amb_we     = 1'b1;
                        count_next = '0;
                    end
                    else if (AW'(sample) < lvl_cur)
                    begin
                        if (count_reg < confirm_needed_reg)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        count_next = '0;
                    end
                    if (count_next >= confirm_needed_reg)
                    begin
                        hit_now         = 1'b1;
                        last_tgt_next   = cur_tgt_reg;
                        wait_start_next = now_ms;
                        count_next      = '0;
                        phase_next      = lthd_pkg::PH_WAIT;
                    end
                end
                else
                begin
                    phase_next = lthd_pkg::PH_SELECT;
                end
            end
            lthd_pkg::PH_WAIT:
            begin
                if (elapsed >= lthd_pkg::TIME_W'(wait_ms_reg))
                begin
                    phase_next = lthd_pkg::PH_SELECT;
                end
            end
            default:
            begin
                phase_next = lthd_pkg::PH_SELECT;
            end
        endcase

        if (phase_next == lthd_pkg::PH_ACTIVE && cur_tgt_next < SENS_N)
        begin
            res_next.target   = cur_tgt_next;
            res_next.led_mask = lthd_pkg::LED_W'(1) << cur_tgt_next;
        end
        else
        begin
            res_next.target   = lthd_pkg::NO_TARGET;
            res_next.led_mask = '0;
        end
        res_next.hit       = hit_now;
        res_next.phase_now = phase_next;
    end

    always_comb
    begin
        base_sel = cfg_index - lthd_pkg::CFG_BASE_A;
        base_val = AW'(cfg_data[lthd_pkg::BASE_W-1:0]);
        base_lvl = floor_sub(base_val, AW'(hit_delta_reg));
        base_wr  = 1'b0;
        unique case (cfg_index) inside
            lthd_pkg::CFG_BASE_A, lthd_pkg::CFG_BASE_B, lthd_pkg::CFG_BASE_C:
            begin
                base_wr = cfg_we;
            end
            default:
            begin
                base_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_delta_reg      <= lthd_pkg::DELTA_RST;
            confirm_needed_reg <= lthd_pkg::CONFIRM_RST;
            wait_ms_reg        <= lthd_pkg::WAIT_RST;
            phase_reg          <= lthd_pkg::PH_SELECT;
            cur_tgt_reg        <= lthd_pkg::NO_TARGET;
            last_tgt_reg       <= lthd_pkg::NO_TARGET;
            wait_start_reg     <= '0;
            count_reg          <= '0;
            for (int i = 0; i < SENSORS; i++)
            begin
                ambient_reg[i] <= AW'(lthd_pkg::BASE_RST);
                level_reg[i]   <= AW'(lthd_pkg::LEVEL_RST);
            end
        end
        else
        begin
            if (in_acc)
            begin
                phase_reg      <= phase_next;
                cur_tgt_reg    <= cur_tgt_next;
                last_tgt_reg   <= last_tgt_next;
                wait_start_reg <= wait_start_next;
                count_reg      <= count_next;
                if (amb_we)
                begin
                    ambient_reg[tidx] <= amb_upd;
                    level_reg[tidx]   <= lvl_upd;
                end
            end
            if (cfg_we)
            begin
                unique case (cfg_index) inside
                    lthd_pkg::CFG_HIT_DELTA:
                        hit_delta_reg <= cfg_data[lthd_pkg::BASE_W-1:0];
                    lthd_pkg::CFG_CONFIRM_NEEDED:
                        confirm_needed_reg <= cfg_data[lthd_pkg::CONF_W-1:0];
                    lthd_pkg::CFG_WAIT_MS:
                        wait_ms_reg <= cfg_data[lthd_pkg::WAIT_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (base_wr)
            begin
                for (int i = 0; i < SENSORS; i++)
                begin
                    if (base_sel == lthd_pkg::CFG_IDX_W'(i))
                    begin
                        ambient_reg[i] <= base_val;
                        level_reg[i]   <= base_lvl;
                    end
                end
            end
        end
    end

    // Output register with one skid entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_acc;
            end
        end
        else if (in_acc)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_acc)
            begin
                out_reg <= res_next;
            end
        end
        else if (in_acc)
        begin
            skid_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign target    = out_reg.target;
    assign led_mask  = out_reg.led_mask;
    assign hit       = out_reg.hit;
    assign phase_now = out_reg.phase_now;

endmodule

// ===== design/lthd_checker.sv =====
// Port-level checks for the light target hit detector, bound to the top level.
// Depends on lthd_pkg and light_target_hit_detector_top.
module lthd_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         out_valid,
    input  logic                         out_stall,
    input  logic [lthd_pkg::TGT_W-1:0]   target,
    input  logic [lthd_pkg::LED_W-1:0]   led_mask,
    input  logic                         hit,
    input  logic [1:0]                   phase_now
);

    a_hit_enters_wait: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> phase_now == 2'(lthd_pkg::PH_WAIT))
        else $error("hit without wait phase");

    a_idle_no_target: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_now != 2'(lthd_pkg::PH_ACTIVE)
        |-> target == lthd_pkg::NO_TARGET && led_mask == '0)
        else $error("target shown outside active phase");

    a_active_led: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase_now == 2'(lthd_pkg::PH_ACTIVE)
        |-> $onehot(led_mask) && target != lthd_pkg::NO_TARGET
            && led_mask == (lthd_pkg::LED_W'(1) << target))
        else $error("led mask does not match target");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(target) && $stable(led_mask)
            && $stable(hit) && $stable(phase_now))
        else $error("stalled item changed");

endmodule

bind light_target_hit_detector_top lthd_checker u_lthd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .target    (target),
    .led_mask  (led_mask),
    .hit       (hit),
    .phase_now (phase_now)
);

// ===== verif/testbench.sv =====
// Testbench of the light target hit detector: a shadow of the phase machine predicts
// every result item and a small scoreboard checks them in order under random stalls.
// Depends on lthd_pkg and light_target_hit_detector_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSENS       = 3;
    localparam int SBITS       = 12;
    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 135;

    localparam logic [lthd_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [lthd_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    class target_shadow;
        logic [lthd_pkg::BASE_W-1:0] delta;
        logic [lthd_pkg::CONF_W-1:0] need;
        logic [lthd_pkg::WAIT_W-1:0] wait_len;
        logic [lthd_pkg::BASE_W-1:0] start_base [NSENS];
        lthd_pkg::phase_t            phase;
        logic [lthd_pkg::TGT_W-1:0]  cur_tgt;
        logic [lthd_pkg::TGT_W-1:0]  last_tgt;
        logic [lthd_pkg::TIME_W-1:0] wait_start;
        logic [lthd_pkg::CONF_W-1:0] confirms;
        logic [lthd_pkg::BASE_W-1:0] ambient [NSENS];
        logic [lthd_pkg::BASE_W-1:0] thresh [NSENS];
        lthd_pkg::result_t           due [$];
        int                          errors;
        int                          reported;
        int                          taken;

        function new();
            delta      = lthd_pkg::DELTA_RST;
            need       = lthd_pkg::CONFIRM_RST;
            wait_len   = lthd_pkg::WAIT_RST;
            phase      = lthd_pkg::PH_SELECT;
            cur_tgt    = lthd_pkg::NO_TARGET;
            last_tgt   = lthd_pkg::NO_TARGET;
            wait_start = '0;
            confirms   = '0;
            for (int i = 0; i < NSENS; i++)
            begin
                start_base[i] = lthd_pkg::BASE_RST;
                ambient[i]    = lthd_pkg::BASE_RST;
                thresh[i]     = floor_sub(lthd_pkg::BASE_RST, lthd_pkg::DELTA_RST);
            end
            errors   = 0;
            reported = 0;
            taken    = 0;
        endfunction

        function logic [lthd_pkg::BASE_W-1:0] floor_sub(logic [lthd_pkg::BASE_W-1:0] b,
                                                        logic [lthd_pkg::BASE_W-1:0] d);
            return (b > d) ? b - d : '0;
        endfunction

        function int pending();
            return due.size();
        endfunction

        function void load_reg(logic [lthd_pkg::CFG_IDX_W-1:0] idx,
                               logic [lthd_pkg::CFG_DATA_W-1:0] data);
            int s;
            case (idx) inside
                lthd_pkg::CFG_HIT_DELTA:      delta    = data[lthd_pkg::BASE_W-1:0];
                lthd_pkg::CFG_CONFIRM_NEEDED: need     = data[lthd_pkg::CONF_W-1:0];
                lthd_pkg::CFG_WAIT_MS:        wait_len = data[lthd_pkg::WAIT_W-1:0];
                lthd_pkg::CFG_BASE_A, lthd_pkg::CFG_BASE_B, lthd_pkg::CFG_BASE_C:
                begin
                    s = int'(idx - lthd_pkg::CFG_BASE_A);
                    start_base[s] = data[lthd_pkg::BASE_W-1:0];
                    ambient[s]    = start_base[s];
                    thresh[s]     = floor_sub(ambient[s], delta);
                end
                default: ;
            endcase
        endfunction

        function void take_tick(logic [SBITS-1:0] smp, bit laser,
                                logic [lthd_pkg::DRAW_W-1:0] draw,
                                logic [lthd_pkg::TIME_W-1:0] now);
            int unsigned t;
            logic [lthd_pkg::TIME_W-1:0] gone;
            lthd_pkg::result_t r;
            r.hit = 1'b0;
            case (phase)
                lthd_pkg::PH_SELECT:
                begin
                    t = draw % NSENS;
                    if (t == last_tgt)
                        t = (t + 1) % NSENS;
                    cur_tgt  = lthd_pkg::TGT_W'(t);
                    confirms = '0;
                    phase    = lthd_pkg::PH_ACTIVE;
                end
                lthd_pkg::PH_ACTIVE:
                begin
                    t = cur_tgt;
                    if (!laser)
                    begin
                        ambient[t] = lthd_pkg::BASE_W'((32'(ambient[t]) * 31 + 32'(smp)) / 32);
                        thresh[t]  = floor_sub(ambient[t], delta);
                        confirms   = '0;
                    end
                    else if (smp < thresh[t])
                    begin
                        if (confirms < need)
                            confirms++;
                    end
                    else
                        confirms = '0;
                    if (confirms >= need)
                    begin
                        r.hit      = 1'b1;
                        last_tgt   = cur_tgt;
                        wait_start = now;
                        confirms   = '0;
                        phase      = lthd_pkg::PH_WAIT;
                    end
                end
                lthd_pkg::PH_WAIT:
                begin
                    gone = now - wait_start;
                    if (gone >= lthd_pkg::TIME_W'(wait_len))
                        phase = lthd_pkg::PH_SELECT;
                end
                default: phase = lthd_pkg::PH_SELECT;
            endcase
            if (phase == lthd_pkg::PH_ACTIVE)
            begin
                r.target   = cur_tgt;
                r.led_mask = lthd_pkg::LED_W'(1 << cur_tgt);
            end
            else
            begin
                r.target   = lthd_pkg::NO_TARGET;
                r.led_mask = '0;
            end
            r.phase_now = phase;
            due.push_back(r);
        endfunction

        function void match_result(lthd_pkg::result_t got);
            lthd_pkg::result_t want;
            if (due.size() == 0)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected result item: target %0d led %b hit %0b phase %0d",
                             got.target, got.led_mask, got.hit, got.phase_now);
                end
                return;
            end
            want = due.pop_front();
            taken++;
            if (got.target !== want.target || got.led_mask !== want.led_mask ||
                got.hit !== want.hit || got.phase_now !== want.phase_now)
            begin
                errors++;
                if (reported < 10)
                begin
                    reported++;
                    $display("result %0d mismatch: expected target %0d led %b hit %0b phase %0d",
                             taken, want.target, want.led_mask, want.hit, want.phase_now);
                    $display("                      actual target %0d led %b hit %0b phase %0d",
                             got.target, got.led_mask, got.hit, got.phase_now);
                end
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic [SBITS-1:0]                sample;
    logic                            laser_on;
    logic [lthd_pkg::DRAW_W-1:0]     random_draw;
    logic [lthd_pkg::TIME_W-1:0]     now_ms;
    logic                            out_valid;
    logic                            out_stall;
    logic [lthd_pkg::TGT_W-1:0]      target;
    logic [lthd_pkg::LED_W-1:0]      led_mask;
    logic                            hit;
    logic [1:0]                      phase_now;
    logic                            cfg_we;
    logic [lthd_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lthd_pkg::CFG_DATA_W-1:0] cfg_data;

    target_shadow                sb;
    logic [lthd_pkg::TIME_W-1:0] now_clock;
    bit                          tx_burst;
    bit                          rx_burst;
    bit                          held_long;
    int                          cycles = 0;

    light_target_hit_detector_top #(
        .SENSORS     (NSENS),
        .SAMPLE_BITS (SBITS)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .laser_on    (laser_on),
        .random_draw (random_draw),
        .now_ms      (now_ms),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .target      (target),
        .led_mask    (led_mask),
        .hit         (hit),
        .phase_now   (phase_now),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.match_result(lthd_pkg::result_t'({target, led_mask, hit, phase_now}));
    end

    initial
    begin
        int hold;
        out_stall = 1'b0;
        rx_burst  = 1'b0;
        held_long = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
                rx_burst = !rx_burst;
            hold = rx_burst ? 0 : $urandom_range(0, 11);
            // hold off long enough for the block to fill and stall its input
            if (!held_long && sb.taken >= 300)
            begin
                hold      = 400;
                held_long = 1'b1;
            end
            @(negedge clk);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    task automatic send_tick(logic [SBITS-1:0] smp, bit laser,
                             logic [lthd_pkg::DRAW_W-1:0] draw,
                             logic [lthd_pkg::TIME_W-1:0] now);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 11);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        sample      <= smp;
        laser_on    <= laser;
        random_draw <= draw;
        now_ms      <= now;
        do @(posedge clk); while (in_stall);
        sb.take_tick(smp, laser, draw, now);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic cfg_write(logic [lthd_pkg::CFG_IDX_W-1:0] idx,
                             logic [lthd_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.load_reg(idx, data);
    endtask

    task automatic apply_setting(int style);
        logic [lthd_pkg::CFG_IDX_W-1:0] regs [8];
        int unsigned v [8];
        int order [8];
        int j;
        int tmp;
        logic [lthd_pkg::CFG_DATA_W-1:0] data;
        regs = '{lthd_pkg::CFG_HIT_DELTA, lthd_pkg::CFG_CONFIRM_NEEDED, lthd_pkg::CFG_WAIT_MS,
                 lthd_pkg::CFG_BASE_A, lthd_pkg::CFG_BASE_B, lthd_pkg::CFG_BASE_C,
                 CFG_SPARE_LO, CFG_SPARE_HI};
        for (int k = 0; k < 8; k++)
        begin
            v[k]     = $urandom;
            order[k] = k;
        end
        case (style)
            0: for (int k = 0; k < 6; k++) v[k] = 0;
            1:
            begin
                v[0] = 4095;
                v[1] = 15;
                v[2] = 65535;
                v[3] = 4095;
                v[4] = 4095;
                v[5] = 4095;
            end
            2:
            begin
                v[0] = 0;
                v[1] = 15;
                v[2] = 65535;
                v[3] = 4095;
                v[4] = 0;
                v[5] = 2048;
            end
            default:
            begin
                v[0] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                   : $urandom_range(0, 600);
                v[1] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
                v[2] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                   : $urandom_range(0, 1500);
                for (int k = 3; k < 6; k++)
                    v[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(2500, 4095);
            end
        endcase
        // shuffle so delta and baseline writes land in either order
        for (int k = 7; k > 0; k--)
        begin
            j        = $urandom_range(0, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
        end
        for (int k = 0; k < 8; k++)
        begin
            data = lthd_pkg::CFG_DATA_W'($urandom);
            case (regs[order[k]]) inside
                lthd_pkg::CFG_HIT_DELTA, lthd_pkg::CFG_BASE_A, lthd_pkg::CFG_BASE_B,
                lthd_pkg::CFG_BASE_C:
                    data[lthd_pkg::BASE_W-1:0] = lthd_pkg::BASE_W'(v[order[k]]);
                lthd_pkg::CFG_CONFIRM_NEEDED:
                    data[lthd_pkg::CONF_W-1:0] = lthd_pkg::CONF_W'(v[order[k]]);
                lthd_pkg::CFG_WAIT_MS:
                    data = lthd_pkg::CFG_DATA_W'(v[order[k]]);
                default: ;
            endcase
            cfg_write(regs[order[k]], data);
        end
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_tick();
        logic [SBITS-1:0] smp;
        bit laser;
        logic [lthd_pkg::DRAW_W-1:0] draw;
        logic [lthd_pkg::BASE_W-1:0] thr;
        int unsigned pick;
        pick  = $urandom_range(0, 99);
        draw  = lthd_pkg::DRAW_W'($urandom_range(0, 3));
        smp   = SBITS'($urandom);
        laser = 1'($urandom);
        if (sb.phase == lthd_pkg::PH_ACTIVE)
        begin
            thr = sb.thresh[sb.cur_tgt];
            if (pick < 20)
            begin
                laser = 1'b0;
                smp   = sb.ambient[sb.cur_tgt] ^ SBITS'($urandom_range(0, 127));
            end
            else if (pick < 75)
            begin
                laser = 1'b1;
                if (thr > 0)
                    smp = SBITS'($urandom_range(0, thr - 1));
            end
            else if (pick < 90)
            begin
                laser = 1'b1;
                smp   = SBITS'($urandom_range(thr, 4095));
            end
        end
        pick = $urandom_range(0, 99);
        if (sb.phase == lthd_pkg::PH_WAIT)
        begin
            if (pick < 50)
                now_clock += $urandom_range(0, 64);
            else if (pick < 85)
                now_clock += $urandom_range(0, 2 * sb.wait_len + 2);
            else if (pick < 95)
                now_clock = sb.wait_start + sb.wait_len - $urandom_range(0, 1);
            else
                now_clock = $urandom;
        end
        else if (pick < 97)
            now_clock += $urandom_range(0, 20);
        else
            now_clock = $urandom;
        send_tick(smp, laser, draw, now_clock);
    endtask

    initial
    begin
        sb          = new();
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        sample      = '0;
        laser_on    = 1'b0;
        random_draw = '0;
        now_ms      = '0;
        cfg_we      = 1'b0;
        cfg_index   = lthd_pkg::CFG_HIT_DELTA;
        cfg_data    = '0;
        tx_burst    = 1'b0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // out-of-range draw, threshold edge, hit across the time wrap, wait boundary
        send_tick(12'hFFF, 1'b1, 2'd3, 32'hFFFF_FF00);
        send_tick(12'h000, 1'b0, 2'd1, 32'hFFFF_FF01);
        send_tick(12'd3766, 1'b1, 2'd2, 32'hFFFF_FF02);
        send_tick(12'd3767, 1'b1, 2'd0, 32'hFFFF_FF03);
        send_tick(12'h000, 1'b1, 2'd0, 32'hFFFF_FF04);
        send_tick(12'h000, 1'b1, 2'd0, 32'hFFFF_FF05);
        send_tick(12'h000, 1'b1, 2'd0, 32'hFFFF_FF10);
        send_tick(12'hFFF, 1'b0, 2'd3, 32'h0000_02F7);
        send_tick(12'hFFF, 1'b0, 2'd3, 32'h0000_02F8);
        // draw equal to the last target, then the wrap of the next index
        send_tick(12'h000, 1'b1, 2'd0, 32'h0000_0300);
        send_tick(12'hFFF, 1'b1, 2'd0, 32'h0000_0301);
        send_tick(12'h000, 1'b1, 2'd1, 32'h0000_0302);
        send_tick(12'h000, 1'b1, 2'd2, 32'h0000_0303);
        send_tick(12'h000, 1'b1, 2'd3, 32'h0000_0310);
        send_tick(12'h000, 1'b0, 2'd0, 32'h0001_0000);
        send_tick(12'h000, 1'b1, 2'd1, 32'h0001_0001);
        send_tick(12'h000, 1'b1, 2'd0, 32'h0001_0002);
        send_tick(12'h000, 1'b1, 2'd0, 32'h0001_0003);
        send_tick(12'h000, 1'b1, 2'd0, 32'h0001_0004);
        send_tick(12'h000, 1'b0, 2'd0, 32'h0002_0000);
        send_tick(12'h000, 1'b1, 2'd2, 32'h0002_0001);
        send_tick(12'hFFF, 1'b1, 2'd0, 32'h0002_0002);
        now_clock = 32'h0002_0010;

        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            apply_setting(p < 3 ? p : 3);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 39) == 0)
                    tx_burst = !tx_burst;
                random_tick();
            end
        end
        wait_idle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
